// ===== sv/tcpw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpw_pkg
// Shared types, codes and constants of the tag-count probability weight block.
// ----------------------------------------------------------------------------
package tcpw_pkg;

  localparam int MAX_JETS_DEF = 8;

  localparam int EFF_W   = 17;  // efficiency, unsigned Q1.16
  localparam int SCL_W   = 16;  // scale factor, unsigned Q2.14
  localparam int SCL_FRAC = 14;
  localparam int CNT_W   = 4;   // tag counts and window limits
  localparam int DP_W    = 20;  // data tag probability, Q.16
  localparam int FACT_W  = 21;  // signed jet factor, Q.16
  localparam int CELL_W  = 48;  // signed table cell, Q16.32
  localparam int HALF_W  = 24;  // cell magnitude is multiplied in two halves
  localparam int PROD_W  = HALF_W + FACT_W;
  localparam int TERM_W  = 56;
  localparam int SUM3_W  = TERM_W + 2;
  localparam int WGT_W   = 32;  // signed Q16.16 weight
  localparam int FRAC_W  = 16;
  localparam int STAT_W  = 2;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [FACT_W-1:0] ONE_Q16 = FACT_W'(65536);

  typedef enum logic [MODE_W-1:0] {
    MODE_TWO_LEVEL = 2'd0,
    MODE_LOOSE     = 2'd1,
    MODE_TIGHT     = 2'd2,
    MODE_ALT_TWO   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEIGHT_MODE = 3'd0,
    CFG_MIN_FIRST   = 3'd1,
    CFG_MAX_FIRST   = 3'd2,
    CFG_MIN_SECOND  = 3'd3,
    CFG_MAX_SECOND  = 3'd4
  } cfg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_REJECTED = 2'd1,
    STAT_SIM_ZERO = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_FACT,
    ST_SWEEP,
    ST_DRAIN,
    ST_SUM,
    ST_SUM_END,
    ST_MAG,
    ST_START,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [CELL_W-1:0] dat;
    logic signed [CELL_W-1:0] sim;
  } cell_pair_t;

  typedef struct packed {
    logic signed [FACT_W-1:0] f2;  // both tags
    logic signed [FACT_W-1:0] f1;  // first kind only
    logic signed [FACT_W-1:0] f0;  // no tag
  } fact_t;

  localparam logic signed [CELL_W-1:0] CELL_ONE = CELL_W'(64'h1_0000_0000);

  function automatic logic in_win(input logic [7:0] v, input logic [CNT_W-1:0] lo,
                                  input logic [CNT_W-1:0] hi);
    in_win = (v >= 8'(lo)) && (v <= 8'(hi));
  endfunction

endpackage

// ===== sv/tag_count_probability_weight.sv =====
// ----------------------------------------------------------------------------
// tag_count_probability_weight
// Builds simulation and data tag-count probability tables jet by jet and
// returns the data/simulation ratio over the count window on the last jet.
// ----------------------------------------------------------------------------
// A jet that is not last takes one table pass, one cell a cycle through the memory
// port. A last jet adds window summing and the divider, which a rejected event skips,
// and the output register. One jet is worked on at a time.
// Reset restores the control registers and marks every cell as reset at once through
// valid bits; there is no clearing pass, and tables clear the same way per event.
module tag_count_probability_weight #(
  parameter int MAX_JETS = tcpw_pkg::MAX_JETS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // eff_loose, scale_loose, eff_tight, scale_tight, event_first_tags,
  // event_second_tags, zero fill
  input  logic [79:0] s_tdata,
  input  logic        s_tlast,    // last_jet
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // event_weight
  output logic [1:0]  m_tuser,    // status
  input  logic        cfg_we,
  input  logic [tcpw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcpw_pkg::CNT_W-1:0]     cfg_data
);

  localparam int DIM   = MAX_JETS + 1;
  localparam int CELLS = DIM * DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(DIM + 1);
  localparam int CW    = $clog2(DIM);
  localparam int JW    = $clog2(MAX_JETS + 1);
  localparam int SUM_W = tcpw_pkg::CELL_W + $clog2(CELLS) + 1;
  localparam int EW    = tcpw_pkg::EFF_W;
  localparam int SW    = tcpw_pkg::SCL_W;
  localparam int FW    = tcpw_pkg::FACT_W;
  localparam int NCW   = tcpw_pkg::CNT_W;
  localparam int WW    = tcpw_pkg::WGT_W;
  localparam int PRW   = EW + SW + 1;

  localparam logic [FW-1:0] ONE_EXT = tcpw_pkg::ONE_Q16;

  tcpw_pkg::state_t state, state_next;

  logic [1:0]     weight_mode;
  logic [NCW-1:0] min_first, max_first, min_second, max_second;
  logic           two;

  logic [EW-1:0]  el, et;
  logic [SW-1:0]  sl, st;
  logic [tcpw_pkg::DP_W-1:0] dl, dt;
  logic           last_q, rej_q;
  tcpw_pkg::fact_t fs, fd;

  logic [JW-1:0]  jets_seen;
  logic           overflowed;
  logic           full;
  logic           accept;

  logic [RW-1:0]  wa;
  logic [CW-1:0]  col;
  logic           s1_act, s1_wr, s1_hasa, s1_hasc;
  logic [AW-1:0]  s1_addr;
  tcpw_pkg::cell_pair_t line [DIM];
  tcpw_pkg::cell_pair_t prev;
  tcpw_pkg::cell_pair_t x1, x2;
  logic           p_vld [3];
  logic [AW-1:0]  p_addr [3];
  logic [1:0]     dcnt;

  logic [CW-1:0]  sa, sb;
  logic [AW-1:0]  sk;
  logic           sum_act, sum_win;
  logic signed [SUM_W-1:0] ps, pd;

  logic           neg_q;
  logic [SUM_W-1:0] ud_q, us_q;
  logic           div_start, div_done;
  logic [WW-1:0]  div_mag;

  logic [WW-1:0]  wgt_q;
  tcpw_pkg::status_t status_q;

  logic           mem_clr, mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  tcpw_pkg::cell_pair_t mem_wdata, mem_rdata;
  logic [CW-1:0]  rd_row;
  logic           out_free;

  assign two      = (weight_mode == tcpw_pkg::MODE_TWO_LEVEL) ||
                    (weight_mode == tcpw_pkg::MODE_ALT_TWO);
  assign full     = jets_seen >= JW'(MAX_JETS);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign rd_row   = CW'(wa - RW'(1));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_mode <= tcpw_pkg::MODE_TWO_LEVEL;
      min_first   <= '0;
      max_first   <= NCW'(8);
      min_second  <= '0;
      max_second  <= NCW'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        tcpw_pkg::CFG_WEIGHT_MODE: weight_mode <= cfg_data[1:0];
        tcpw_pkg::CFG_MIN_FIRST:   min_first   <= cfg_data;
        tcpw_pkg::CFG_MAX_FIRST:   max_first   <= cfg_data;
        tcpw_pkg::CFG_MIN_SECOND:  min_second  <= cfg_data;
        tcpw_pkg::CFG_MAX_SECOND:  max_second  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcpw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    mem_clr    = 1'b0;
    div_start  = 1'b0;
    case (state)
      tcpw_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (accept) begin
          if (full) begin
            state_next = s_tlast ? tcpw_pkg::ST_OUT : tcpw_pkg::ST_IDLE;
          end else begin
            state_next = tcpw_pkg::ST_SCALE;
          end
        end
      end
      tcpw_pkg::ST_SCALE: state_next = tcpw_pkg::ST_FACT;
      tcpw_pkg::ST_FACT:  state_next = tcpw_pkg::ST_SWEEP;
      tcpw_pkg::ST_SWEEP: begin
        mem_re    = (wa != '0);
        mem_raddr = AW'(rd_row * DIM) + AW'(col);
        if (wa == '0 && col == CW'(DIM - 1)) begin
          state_next = tcpw_pkg::ST_DRAIN;
        end
      end
      tcpw_pkg::ST_DRAIN: begin
        if (dcnt == 2'd3) begin
          if (!last_q) begin
            state_next = tcpw_pkg::ST_IDLE;
          end else if (rej_q) begin
            state_next = tcpw_pkg::ST_OUT;
          end else begin
            state_next = tcpw_pkg::ST_SUM;
          end
        end
      end
      tcpw_pkg::ST_SUM: begin
        mem_re    = 1'b1;
        mem_raddr = sk;
        if (sk == AW'(CELLS - 1)) begin
          state_next = tcpw_pkg::ST_SUM_END;
        end
      end
      tcpw_pkg::ST_SUM_END: state_next = tcpw_pkg::ST_MAG;
      tcpw_pkg::ST_MAG: begin
        state_next = (ps == '0) ? tcpw_pkg::ST_OUT : tcpw_pkg::ST_START;
      end
      tcpw_pkg::ST_START: begin
        div_start  = 1'b1;
        state_next = tcpw_pkg::ST_DIV;
      end
      tcpw_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = tcpw_pkg::ST_OUT;
        end
      end
      tcpw_pkg::ST_OUT: begin
        if (out_free) begin
          mem_clr    = 1'b1;
          state_next = tcpw_pkg::ST_IDLE;
        end
      end
      default: state_next = tcpw_pkg::ST_IDLE;
    endcase
  end

  // Jet bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      jets_seen  <= '0;
      overflowed <= 1'b0;
    end else if (state == tcpw_pkg::ST_OUT && out_free) begin
      jets_seen  <= '0;
      overflowed <= 1'b0;
    end else if (accept) begin
      if (full) begin
        overflowed <= 1'b1;
      end else begin
        jets_seen <= jets_seen + 1'b1;
      end
    end
  end

  // Item capture and jet factors
  always_ff @(posedge clk) begin
    if (accept) begin
      el     <= s_tdata[16:0];
      sl     <= s_tdata[32:17];
      et     <= s_tdata[49:33];
      st     <= s_tdata[65:50];
      last_q <= s_tlast;
      rej_q  <= !tcpw_pkg::in_win(8'(s_tdata[69:66]), min_first, max_first) ||
                (two && !tcpw_pkg::in_win(8'(s_tdata[73:70]), min_second, max_second));
    end
    if (state == tcpw_pkg::ST_SCALE) begin
      dl <= tcpw_pkg::DP_W'((PRW'(el) * PRW'(sl) + PRW'(1 << (tcpw_pkg::SCL_FRAC - 1)))
                            >> tcpw_pkg::SCL_FRAC);
      dt <= tcpw_pkg::DP_W'((PRW'(et) * PRW'(st) + PRW'(1 << (tcpw_pkg::SCL_FRAC - 1)))
                            >> tcpw_pkg::SCL_FRAC);
    end
    if (state == tcpw_pkg::ST_FACT) begin
      if (two) begin
        fs.f0 <= FW'(ONE_EXT) - FW'(el);
        fs.f1 <= FW'(el) - FW'(et);
        fs.f2 <= FW'(et);
        fd.f0 <= FW'(ONE_EXT) - FW'(dl);
        fd.f1 <= FW'(dl) - FW'(dt);
        fd.f2 <= FW'(dt);
      end else if (weight_mode == tcpw_pkg::MODE_LOOSE) begin
        fs.f0 <= FW'(ONE_EXT) - FW'(el);
        fs.f1 <= FW'(el);
        fs.f2 <= '0;
        fd.f0 <= FW'(ONE_EXT) - FW'(dl);
        fd.f1 <= FW'(dl);
        fd.f2 <= '0;
      end else begin
        fs.f0 <= FW'(ONE_EXT) - FW'(et);
        fs.f1 <= FW'(et);
        fs.f2 <= '0;
        fd.f0 <= FW'(ONE_EXT) - FW'(dt);
        fd.f1 <= FW'(dt);
        fd.f2 <= '0;
      end
    end
  end

  // Table pass: rows from the top down, so each cell reads only older cells.
  // The line holds the old row being rewritten; the memory supplies the row below.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_act <= 1'b0;
      dcnt   <= '0;
    end else begin
      s1_act <= (state == tcpw_pkg::ST_SWEEP);
      dcnt   <= (state == tcpw_pkg::ST_DRAIN) ? dcnt + 1'b1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tcpw_pkg::ST_FACT) begin
      wa  <= RW'(DIM);
      col <= '0;
    end else if (state == tcpw_pkg::ST_SWEEP) begin
      if (col == CW'(DIM - 1)) begin
        col <= '0;
        wa  <= wa - 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
    s1_wr   <= (wa != RW'(DIM));
    s1_addr <= AW'(wa * DIM) + AW'(col);
    s1_hasa <= (wa != '0);
    s1_hasc <= (col != '0);
    if (s1_act) begin
      for (int i = 0; i < DIM - 1; i++) begin
        line[i] <= line[i + 1];
      end
      line[DIM-1] <= mem_rdata;
      prev        <= mem_rdata;
    end
  end

  assign x1 = s1_hasa ? mem_rdata : '0;
  assign x2 = (s1_hasa && s1_hasc) ? prev : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        p_vld[i] <= 1'b0;
      end
    end else begin
      p_vld[0] <= s1_act && s1_wr;
      p_vld[1] <= p_vld[0];
      p_vld[2] <= p_vld[1];
    end
  end

  always_ff @(posedge clk) begin
    p_addr[0] <= s1_addr;
    p_addr[1] <= p_addr[0];
    p_addr[2] <= p_addr[1];
  end

  tcpw_mac u_mac_sim (
    .clk  (clk),
    .x0   (line[0].sim),
    .x1   (x1.sim),
    .x2   (x2.sim),
    .fact (fs),
    .upd  (mem_wdata.sim)
  );

  tcpw_mac u_mac_dat (
    .clk  (clk),
    .x0   (line[0].dat),
    .x1   (x1.dat),
    .x2   (x2.dat),
    .fact (fd),
    .upd  (mem_wdata.dat)
  );

  assign mem_we    = p_vld[2];
  assign mem_waddr = p_addr[2];

  tcpw_mem #(
    .CELLS (CELLS)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .clr   (mem_clr),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Window sums over every cell in row-major order
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_act <= 1'b0;
    end else begin
      sum_act <= (state == tcpw_pkg::ST_SUM);
    end
  end

  always_ff @(posedge clk) begin
    if (state == tcpw_pkg::ST_DRAIN) begin
      sa <= '0;
      sb <= '0;
      sk <= '0;
      ps <= '0;
      pd <= '0;
    end else begin
      if (state == tcpw_pkg::ST_SUM) begin
        sk <= sk + 1'b1;
        if (sb == CW'(DIM - 1)) begin
          sb <= '0;
          sa <= sa + 1'b1;
        end else begin
          sb <= sb + 1'b1;
        end
      end
      if (sum_act && sum_win) begin
        ps <= ps + SUM_W'(mem_rdata.sim);
        pd <= pd + SUM_W'(mem_rdata.dat);
      end
    end
    sum_win <= tcpw_pkg::in_win(8'(sa), min_first, max_first) &&
               (two ? tcpw_pkg::in_win(8'(sb), min_second, max_second) : (sb == '0));
    if (state == tcpw_pkg::ST_MAG) begin
      neg_q <= ps[SUM_W-1] ^ pd[SUM_W-1];
      ud_q  <= pd[SUM_W-1] ? SUM_W'(-pd) : SUM_W'(pd);
      us_q  <= ps[SUM_W-1] ? SUM_W'(-ps) : SUM_W'(ps);
    end
  end

  tcpw_div #(
    .MAG_W (SUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .ud    (ud_q),
    .us    (us_q),
    .done  (div_done),
    .mag   (div_mag)
  );

  // Result and status
  always_ff @(posedge clk) begin
    if (state == tcpw_pkg::ST_IDLE && accept && full) begin
      wgt_q    <= '0;
      status_q <= tcpw_pkg::STAT_OVERFLOW;
    end else if (state == tcpw_pkg::ST_DRAIN) begin
      wgt_q    <= '0;
      status_q <= tcpw_pkg::STAT_REJECTED;
    end else if (state == tcpw_pkg::ST_MAG) begin
      wgt_q    <= '0;
      status_q <= tcpw_pkg::STAT_SIM_ZERO;
    end else if (state == tcpw_pkg::ST_DIV && div_done) begin
      status_q <= tcpw_pkg::STAT_OK;
      if (neg_q) begin
        wgt_q <= div_mag[WW-1] ? {1'b1, {(WW-1){1'b0}}} : WW'(~div_mag + 1'b1);
      end else begin
        wgt_q <= div_mag[WW-1] ? {1'b0, {(WW-1){1'b1}}} : div_mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == tcpw_pkg::ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tcpw_pkg::ST_OUT && out_free) begin
      m_tdata <= wgt_q;
      m_tuser <= status_q;
    end
  end

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("table read and write hit the same cell");

  a_jets_bound: assert property (@(posedge clk) disable iff (rst)
    jets_seen <= JW'(MAX_JETS))
    else $error("jet count beyond table depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> jets_seen == JW'(MAX_JETS))
    else $error("overflow flagged before tables were full");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == tcpw_pkg::ST_OUT))
    else $error("result item raised outside the output state");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    state == tcpw_pkg::ST_IDLE |-> !p_vld[0] && !p_vld[1] && !p_vld[2])
    else $error("item taken while cell writes are pending");

endmodule

// ===== sv/tcpw_mem.sv =====
// ----------------------------------------------------------------------------
// tcpw_mem
// Probability table store: one write and one registered read a cycle, with a
// valid bit per cell so that a whole table returns to its reset contents at once.
// ----------------------------------------------------------------------------
module tcpw_mem #(
  parameter int CELLS = 81
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clr,
  input  logic                        we,
  input  logic [$clog2(CELLS)-1:0]    waddr,
  input  tcpw_pkg::cell_pair_t        wdata,
  input  logic                        re,
  input  logic [$clog2(CELLS)-1:0]    raddr,
  output tcpw_pkg::cell_pair_t        rdata
);

  tcpw_pkg::cell_pair_t ram [CELLS];
  tcpw_pkg::cell_pair_t ram_q;
  logic [CELLS-1:0]     vld;
  logic                 vld_q;
  logic                 zero_q;

  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
    if (re) begin
      ram_q  <= ram[raddr];
      vld_q  <= vld[raddr];
      zero_q <= (raddr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  // A cell never written since the last clear reads as its reset value.
  always_comb begin
    if (vld_q) begin
      rdata = ram_q;
    end else if (zero_q) begin
      rdata = '{dat: tcpw_pkg::CELL_ONE, sim: tcpw_pkg::CELL_ONE};
    end else begin
      rdata = '0;
    end
  end

endmodule

// ===== sv/tcpw_mac.sv =====
// ----------------------------------------------------------------------------
// tcpw_mac
// Three-stage cell update: three cell-by-factor products rounded to Q.32,
// summed and saturated to the cell width.
// ----------------------------------------------------------------------------
module tcpw_mac (
  input  logic                                clk,
  input  logic signed [tcpw_pkg::CELL_W-1:0]  x0,
  input  logic signed [tcpw_pkg::CELL_W-1:0]  x1,
  input  logic signed [tcpw_pkg::CELL_W-1:0]  x2,
  input  tcpw_pkg::fact_t                     fact,
  output logic signed [tcpw_pkg::CELL_W-1:0]  upd
);

  localparam int CW = tcpw_pkg::CELL_W;
  localparam int FW = tcpw_pkg::FACT_W;
  localparam int HW = tcpw_pkg::HALF_W;
  localparam int PW = tcpw_pkg::PROD_W;
  localparam int TW = tcpw_pkg::TERM_W;
  localparam int SW = tcpw_pkg::SUM3_W;
  localparam int RW = PW + 9;

  localparam logic signed [SW-1:0] C_MAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] C_MIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic signed [CW-1:0] xs [3];
  logic signed [FW-1:0] fs [3];
  logic        [CW-1:0] ux [3];
  logic        [FW-1:0] uf [3];
  logic        [PW-1:0] hp [3];
  logic        [PW-1:0] lp [3];
  logic                 neg [3];
  logic        [PW-1:0] hp_q [3];
  logic        [PW-1:0] lp_q [3];
  logic                 neg_q [3];
  logic        [RW-1:0] r [3];
  logic signed [TW-1:0] term [3];
  logic signed [TW-1:0] term_q [3];
  logic signed [SW-1:0] s;

  assign xs[0] = x0;
  assign xs[1] = x1;
  assign xs[2] = x2;
  assign fs[0] = fact.f0;
  assign fs[1] = fact.f1;
  assign fs[2] = fact.f2;

  // Magnitudes are multiplied in two halves of the cell, as in the rounding rule.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg[i] = xs[i][CW-1] ^ fs[i][FW-1];
      ux[i]  = xs[i][CW-1] ? CW'(-xs[i]) : CW'(xs[i]);
      uf[i]  = fs[i][FW-1] ? FW'(-fs[i]) : FW'(fs[i]);
      hp[i]  = PW'(ux[i][CW-1:HW]) * PW'(uf[i]);
      lp[i]  = PW'(ux[i][HW-1:0]) * PW'(uf[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      hp_q[i]  <= hp[i];
      lp_q[i]  <= lp[i];
      neg_q[i] <= neg[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r[i]    = (RW'(hp_q[i]) << 8) + RW'((RW'(lp_q[i]) + RW'(32'h8000)) >> 16);
      term[i] = neg_q[i] ? -$signed(TW'(r[i])) : $signed(TW'(r[i]));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      term_q[i] <= term[i];
    end
  end

  assign s = SW'(term_q[0]) + SW'(term_q[1]) + SW'(term_q[2]);

  always_ff @(posedge clk) begin
    if (s > C_MAX) begin
      upd <= C_MAX[CW-1:0];
    end else if (s < C_MIN) begin
      upd <= C_MIN[CW-1:0];
    end else begin
      upd <= s[CW-1:0];
    end
  end

endmodule

// ===== sv/tcpw_div.sv =====
// ----------------------------------------------------------------------------
// tcpw_div
// Restoring divider giving the Q16.16 magnitude of one sum over another,
// one quotient bit a cycle, saturating at 2^31.
// ----------------------------------------------------------------------------
module tcpw_div #(
  parameter int MAG_W = 56
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [MAG_W-1:0]              ud,
  input  logic [MAG_W-1:0]              us,
  output logic                          done,
  output logic [tcpw_pkg::WGT_W-1:0]    mag
);

  localparam int QB  = tcpw_pkg::WGT_W - 1;
  localparam int HI  = QB - tcpw_pkg::FRAC_W;
  localparam int RMW = MAG_W + tcpw_pkg::FRAC_W;
  localparam int DW  = MAG_W + QB;
  localparam int NW  = $clog2(QB);

  logic           busy;
  logic [NW-1:0]  cnt;
  logic [RMW-1:0] rem;
  logic [DW-1:0]  den;
  logic [QB-1:0]  q;
  logic           fits;
  logic [QB-1:0]  q_next;

  assign fits   = DW'(rem) >= den;
  assign q_next = {q[QB-2:0], fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // A quotient of 2^15 or more saturates without iterating.
        if (DW'(ud) >= (DW'(us) << HI)) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= RMW'(ud) << tcpw_pkg::FRAC_W;
      den <= DW'(us) << (QB - 1);
      cnt <= NW'(QB - 1);
      q   <= '0;
      mag <= tcpw_pkg::WGT_W'(1) << QB;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - RMW'(den);
      end
      den <= den >> 1;
      q   <= q_next;
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        mag <= {1'b0, q_next};
      end
    end
  end

endmodule

// ===== tb/tag_count_probability_weight_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tag_count_probability_weight_tb
// Streams events of jets into the weight block and checks every event weight
// and status against a predictor of the tag-count probability tables.
// ----------------------------------------------------------------------------
module tag_count_probability_weight_tb;

  localparam int NJETS     = tcpw_pkg::MAX_JETS_DEF;
  localparam int NDIM      = NJETS + 1;
  localparam int NCELLS    = NDIM * NDIM;
  localparam longint CELL_HI = (64'sd1 <<< 47) - 1;
  localparam longint CELL_LO = -(64'sd1 <<< 47);
  localparam int SETTLE    = 300;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [tcpw_pkg::WGT_W-1:0] weight;
    tcpw_pkg::status_t                 status;
  } weight_result_t;

  class weight_scoreboard;
    tcpw_pkg::mode_t mode;
    logic [3:0]     lo1, hi1, lo2, hi2;
    longint         sim_tab[NCELLS];
    longint         dat_tab[NCELLS];
    int             jets;
    bit             ovf;
    weight_result_t pending_q[$];
    int             errors;

    function void clear_tables();
      foreach (sim_tab[i]) begin
        sim_tab[i] = 0;
        dat_tab[i] = 0;
      end
      sim_tab[0] = 64'sd1 <<< 32;
      dat_tab[0] = 64'sd1 <<< 32;
      jets = 0;
      ovf  = 0;
    endfunction

    function void reset_state();
      mode = tcpw_pkg::MODE_TWO_LEVEL;
      lo1 = 0; hi1 = 8; lo2 = 0; hi2 = 8;
      errors = 0;
      clear_tables();
    endfunction

    function void write_reg(tcpw_pkg::cfg_idx_t idx, logic [3:0] v);
      case (idx)
        tcpw_pkg::CFG_WEIGHT_MODE: mode = tcpw_pkg::mode_t'(v[1:0]);
        tcpw_pkg::CFG_MIN_FIRST:   lo1 = v;
        tcpw_pkg::CFG_MAX_FIRST:   hi1 = v;
        tcpw_pkg::CFG_MIN_SECOND:  lo2 = v;
        tcpw_pkg::CFG_MAX_SECOND:  hi2 = v;
        default: ;
      endcase
    endfunction

    // Q.32 cell times Q.16 factor, magnitude split in two halves, rounded.
    function longint mul_q(longint a, longint f);
      bit neg;
      longint unsigned ua, uf, r;
      neg = (a < 0) != (f < 0);
      ua = a < 0 ? -a : a;
      uf = f < 0 ? -f : f;
      r = (((ua >> 24) * uf) << 8) + (((ua & 64'hFF_FFFF) * uf + 64'h8000) >> 16);
      return neg ? -longint'(r) : longint'(r);
    endfunction

    function void advance(bit use_data, longint f0, longint f1, longint f2, bit two);
      longint t[NCELLS];
      longint s;
      t = use_data ? dat_tab : sim_tab;
      for (int a = NDIM - 1; a >= 0; a--) begin
        for (int b = NDIM - 1; b >= 0; b--) begin
          s = mul_q(t[a*NDIM+b], f0);
          if (a > 0) begin
            s += mul_q(t[(a-1)*NDIM+b], f1);
            if (two && b > 0) s += mul_q(t[(a-1)*NDIM+b-1], f2);
          end
          t[a*NDIM+b] = s > CELL_HI ? CELL_HI : (s < CELL_LO ? CELL_LO : s);
        end
      end
      if (use_data) dat_tab = t;
      else sim_tab = t;
    endfunction

    function bit in_range(int v, logic [3:0] lo, logic [3:0] hi);
      return v >= lo && v <= hi;
    endfunction

    function logic signed [31:0] ratio_q16(longint d, longint s);
      bit neg;
      longint unsigned ud, us, q, r, mag;
      neg = (d < 0) != (s < 0);
      ud = d < 0 ? -d : d;
      us = s < 0 ? -s : s;
      q = ud / us;
      r = ud % us;
      if (q >= (64'd1 << 15)) begin
        mag = 64'd1 << 31;
      end else begin
        mag = q;
        for (int i = 0; i < 16; i++) begin
          r = r << 1;
          mag = mag << 1;
          if (r >= us) begin
            r -= us;
            mag |= 1;
          end
        end
      end
      if (neg) return mag >= (64'd1 << 31) ? 32'sh8000_0000 : -$signed(32'(mag));
      return mag > 64'h7FFF_FFFF ? 32'sh7FFF_FFFF : $signed(32'(mag));
    endfunction

    function void note_jet(longint el, longint sl, longint et, longint st,
                           int n1, int n2, bit last);
      bit two;
      longint dl, dt, ps, pd;
      weight_result_t res;
      two = mode == tcpw_pkg::MODE_TWO_LEVEL || mode == tcpw_pkg::MODE_ALT_TWO;
      dl = (el * sl + 64'h2000) >>> 14;
      dt = (et * st + 64'h2000) >>> 14;
      if (jets >= NJETS) begin
        ovf = 1;
      end else begin
        if (two) begin
          advance(0, 65536 - el, el - et, et, 1);
          advance(1, 65536 - dl, dl - dt, dt, 1);
        end else if (mode == tcpw_pkg::MODE_LOOSE) begin
          advance(0, 65536 - el, el, 0, 0);
          advance(1, 65536 - dl, dl, 0, 0);
        end else begin
          advance(0, 65536 - et, et, 0, 0);
          advance(1, 65536 - dt, dt, 0, 0);
        end
        jets++;
      end
      if (!last) return;
      res.weight = 0;
      res.status = tcpw_pkg::STAT_OK;
      if (ovf) begin
        res.status = tcpw_pkg::STAT_OVERFLOW;
      end else if (!in_range(n1, lo1, hi1) || (two && !in_range(n2, lo2, hi2))) begin
        res.status = tcpw_pkg::STAT_REJECTED;
      end else begin
        ps = 0;
        pd = 0;
        for (int a = 0; a < NDIM; a++) begin
          for (int b = 0; b < NDIM; b++) begin
            if (in_range(a, lo1, hi1) && (two ? in_range(b, lo2, hi2) : b == 0)) begin
              ps += sim_tab[a*NDIM+b];
              pd += dat_tab[a*NDIM+b];
            end
          end
        end
        if (ps == 0) res.status = tcpw_pkg::STAT_SIM_ZERO;
        else res.weight = ratio_q16(pd, ps);
      end
      pending_q = {pending_q, res};
      clear_tables();
    endfunction

    function void check_result(logic [31:0] w, logic [1:0] st);
      weight_result_t exp_r;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: weight %h status %0d", w, st);
        return;
      end
      exp_r = pending_q.pop_front();
      if (w !== exp_r.weight || st !== exp_r.status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: weight %h status %0d, expected weight %h status %0d",
                   w, st, exp_r.weight, exp_r.status);
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        s_tvalid, s_tready, s_tlast;
  logic [79:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we;
  logic [tcpw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tcpw_pkg::CNT_W-1:0]     cfg_data;

  weight_scoreboard sb;
  int snd_idle, rcv_idle;
  int cycles;

  tag_count_probability_weight u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Result side: sample at the rising edge, change ready at the falling one.
  initial begin
    m_tready = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      @(negedge clk);
      m_tready = $urandom_range(99) >= rcv_idle;
    end
  end

  task automatic send_jet(logic [16:0] el, logic [15:0] sl, logic [16:0] et,
                          logic [15:0] st, logic [3:0] n1, logic [3:0] n2, bit last);
    while ($urandom_range(99) < snd_idle) begin
      s_tvalid = 0;
      @(negedge clk);
    end
    s_tdata  = {6'd0, n2, n1, st, et, sl, el};
    s_tlast  = last;
    s_tvalid = 1;
    do @(posedge clk); while (!s_tready);
    sb.note_jet(el, sl, et, st, n1, n2, last);
    @(negedge clk);
  endtask

  // Waits until every result has arrived and the block has finished any
  // jet that produces none.
  task automatic drain();
    s_tvalid = 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(tcpw_pkg::cfg_idx_t idx, logic [3:0] v);
    cfg_we    = 1;
    cfg_index = idx;
    cfg_data  = v;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_config(logic [3:0] md, logic [3:0] a, logic [3:0] b,
                            logic [3:0] c, logic [3:0] d);
    drain();
    write_reg(tcpw_pkg::CFG_WEIGHT_MODE, md);
    write_reg(tcpw_pkg::CFG_MIN_FIRST, a);
    write_reg(tcpw_pkg::CFG_MAX_FIRST, b);
    write_reg(tcpw_pkg::CFG_MIN_SECOND, c);
    write_reg(tcpw_pkg::CFG_MAX_SECOND, d);
  endtask

  task automatic random_event(output int nj);
    logic [16:0] el, et;
    nj = ($urandom_range(19) == 0) ? $urandom_range(10, 9) : $urandom_range(8, 1);
    for (int j = 1; j <= nj; j++) begin
      el = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
      et = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
      if ($urandom_range(9) == 0) et = el;
      send_jet(el, 16'($urandom), et, 16'($urandom),
               ($urandom_range(7) == 0) ? 4'($urandom) : 4'($urandom_range(8)),
               ($urandom_range(7) == 0) ? 4'($urandom) : 4'($urandom_range(8)),
               j == nj);
    end
  endtask

  initial begin
    int sent;
    int nj;
    int next_cfg;
    sb = new();
    sb.reset_state();
    rst = 1;
    s_tvalid = 0; s_tlast = 0; s_tdata = '0;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    snd_idle = 28; rcv_idle = 66;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed part at reset settings: extremes of every field.
    send_jet(17'd0, 16'd0, 17'd0, 16'd0, 4'd0, 4'd0, 1);
    send_jet(17'd65536, 16'hFFFF, 17'd65536, 16'hFFFF, 4'd1, 4'd1, 1);
    send_jet(17'h1FFFF, 16'hFFFF, 17'h1FFFF, 16'd0, 4'd15, 4'd15, 1);
    send_jet(17'd32768, 16'd16384, 17'd16384, 16'd20000, 4'd0, 4'd0, 0);
    send_jet(17'd40000, 16'd16384, 17'd1000, 16'd30000, 4'd2, 4'd1, 1);
    // Too many jets.
    for (int j = 0; j <= NJETS; j++)
      send_jet(17'd30000, 16'd16000, 17'd10000, 16'd17000, 4'd3, 4'd1, j == NJETS);
    // Zero simulated sum: every jet is surely loose tagged, window wants none.
    set_config(tcpw_pkg::MODE_LOOSE, 4'd0, 4'd0, 4'd0, 4'd8);
    send_jet(17'd65536, 16'd16384, 17'd0, 16'd0, 4'd0, 4'd5, 1);
    set_config(tcpw_pkg::MODE_TIGHT, 4'd1, 4'd8, 4'd15, 4'd15);
    send_jet(17'd0, 16'd0, 17'd50000, 16'd16000, 4'd1, 4'd0, 0);
    send_jet(17'd0, 16'd0, 17'd60000, 16'd12000, 4'd0, 4'd0, 1);
    // Alternative two-level mode, and a window whose minimum is above its maximum.
    set_config(tcpw_pkg::MODE_ALT_TWO, 4'd0, 4'd8, 4'd5, 4'd2);
    send_jet(17'd40000, 16'd16384, 17'd20000, 16'd16384, 4'd1, 4'd3, 1);
    set_config(tcpw_pkg::MODE_ALT_TWO, 4'd0, 4'd8, 4'd0, 4'd8);
    send_jet(17'd40000, 16'd16384, 17'd20000, 16'd16384, 4'd1, 4'd0, 1);
    // Mode change in the middle of an event.
    set_config(tcpw_pkg::MODE_TWO_LEVEL, 4'd0, 4'd8, 4'd0, 4'd8);
    send_jet(17'd45000, 16'd15000, 17'd25000, 16'd18000, 4'd0, 4'd0, 0);
    drain();
    write_reg(tcpw_pkg::CFG_WEIGHT_MODE, tcpw_pkg::MODE_LOOSE);
    send_jet(17'd35000, 16'd17000, 17'd5000, 16'd18000, 4'd1, 4'd0, 1);

    // Random part in three idling phases, counted in jets.
    sent = 0;
    next_cfg = 0;
    while (sent < 920) begin
      if (sent >= next_cfg) begin
        next_cfg += 40;
        if ($urandom_range(4) == 0)
          set_config(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                     4'($urandom));
        else
          set_config(4'($urandom_range(3)), 4'($urandom_range(3)),
                     4'($urandom_range(8, 3)), 4'($urandom_range(3)),
                     4'($urandom_range(8, 2)));
      end
      if (sent >= 610) begin
        snd_idle = 0; rcv_idle = 0;
      end else if (sent >= 300) begin
        snd_idle = 66; rcv_idle = 28;
      end
      random_event(nj);
      sent += nj;
    end
    set_config(tcpw_pkg::MODE_TWO_LEVEL, 4'd0, 4'd8, 4'd0, 4'd8);
    send_jet(17'd20000, 16'd16384, 17'd8000, 16'd16384, 4'd0, 4'd0, 1);

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
